// File: sv/vector3_alu_macros.svh
// ----------------------------------------------------------------------------
// vector3_alu assertion macros
// Shorthand for clocked concurrent checks, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_ALU_MACROS_SVH
`define VECTOR3_ALU_MACROS_SVH

// antecedent implies consequent in the same cycle
`define V3A_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define V3A_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/v3a_pkg.sv
// ----------------------------------------------------------------------------
// v3a_pkg
// Shared types, codes and saturation helper for the vector3 ALU.
// ----------------------------------------------------------------------------
package v3a_pkg;

  localparam int WORD_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int SQRT_STAGES   = 32;
  localparam int SQ_W          = 64;
  localparam int PROD_W        = 64;
  localparam int SUM_W         = PROD_W + 2;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_SCALE,
    OP_HADAMARD,
    OP_NORM,
    OP_DOT,
    OP_MAG
  } op_t;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_SAT       = 2'd1;
  localparam logic [1:0] STAT_ZERO_NORM = 2'd2;

  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef struct packed {
    logic                     ovf;
    logic signed [WORD_W-1:0] val;
  } sat_t;

  function automatic sat_t sat_word(input logic signed [SUM_W-1:0] v);
    sat_t s;
    s.ovf = (v[SUM_W-1:WORD_W-1] != {(SUM_W-WORD_W+1){v[SUM_W-1]}});
    if (!s.ovf) begin
      s.val = v[WORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      s.val = WORD_MIN;
    end else begin
      s.val = WORD_MAX;
    end
    return s;
  endfunction

endpackage

// File: sv/v3a_if.sv
// ----------------------------------------------------------------------------
// v3a channel interfaces
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface v3a_in_if;
  import v3a_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [2:0]               operation;
  logic signed [WORD_W-1:0] a_x;
  logic signed [WORD_W-1:0] a_y;
  logic signed [WORD_W-1:0] a_z;
  logic signed [WORD_W-1:0] b_x;
  logic signed [WORD_W-1:0] b_y;
  logic signed [WORD_W-1:0] b_z;
  logic signed [WORD_W-1:0] factor;

  modport source (output valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, factor,
                  input ready);
  modport sink   (input valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, factor,
                  output ready);
endinterface

interface v3a_out_if;
  import v3a_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] r_x;
  logic signed [WORD_W-1:0] r_y;
  logic signed [WORD_W-1:0] r_z;
  logic signed [WORD_W-1:0] scalar_out;
  logic [1:0]               status;

  modport source (output valid, r_x, r_y, r_z, scalar_out, status, input ready);
  modport sink   (input valid, r_x, r_y, r_z, scalar_out, status, output ready);
endinterface

// File: sv/v3a_lane.sv
// ----------------------------------------------------------------------------
// v3a_lane
// One component lane: multiplier and adder in stage 1, shift and saturate in
// stage 2.
// ----------------------------------------------------------------------------
module v3a_lane import v3a_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  op_t                      op,
  input  logic signed [WORD_W-1:0] a,
  input  logic signed [WORD_W-1:0] b,
  input  logic signed [WORD_W-1:0] f,
  output logic signed [PROD_W-1:0] prod_s1,
  output sat_t                     res_s2,
  output logic signed [WORD_W-1:0] a_s2
);

  logic signed [WORD_W-1:0] mb;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [WORD_W:0]   sum_nxt;
  sat_t                     res_nxt;

  op_t                      op1_r;
  logic signed [PROD_W-1:0] prod1_r;
  logic signed [WORD_W:0]   sum1_r;
  logic signed [WORD_W-1:0] a1_r;
  sat_t                     res2_r;
  logic signed [WORD_W-1:0] a2_r;

  // single multiplier shared by scale, hadamard, dot and the squares
  always_comb begin
    case (op) inside
      OP_SCALE:       mb = f;
      OP_NORM, OP_MAG: mb = a;
      default:        mb = b;
    endcase
    prod_nxt = PROD_W'(a) * PROD_W'(mb);
    if (op == OP_SUB) begin
      sum_nxt = (WORD_W+1)'(a) - (WORD_W+1)'(b);
    end else begin
      sum_nxt = (WORD_W+1)'(a) + (WORD_W+1)'(b);
    end
  end

  always_comb begin
    case (op1_r) inside
      OP_ADD, OP_SUB:        res_nxt = sat_word(SUM_W'(sum1_r));
      OP_SCALE, OP_HADAMARD: res_nxt = sat_word(SUM_W'(prod1_r >>> FRAC_BITS));
      default:               res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r   <= op;
      prod1_r <= prod_nxt;
      sum1_r  <= sum_nxt;
      a1_r    <= a;
      res2_r  <= res_nxt;
      a2_r    <= a1_r;
    end
  end

  assign prod_s1 = prod1_r;
  assign res_s2  = res2_r;
  assign a_s2    = a2_r;

endmodule

// File: sv/v3a_isqrt.sv
// ----------------------------------------------------------------------------
// v3a_isqrt
// Pipelined integer square root, one result bit per stage, floor rounding.
// ----------------------------------------------------------------------------
module v3a_isqrt import v3a_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   n_in,
  output logic [WORD_W-1:0] root
);

  logic [SQ_W-1:0] n_r   [SQRT_STAGES];
  logic [SQ_W-1:0] res_r [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2*s);
    logic [SQ_W-1:0] n_p, res_p, trial, n_nxt, res_nxt;

    if (s == 0) begin : g_first
      assign n_p   = n_in;
      assign res_p = '0;
    end else begin : g_rest
      assign n_p   = n_r[s-1];
      assign res_p = res_r[s-1];
    end

    always_comb begin
      trial = res_p + BIT;
      if (n_p >= trial) begin
        n_nxt   = n_p - trial;
        res_nxt = (res_p >> 1) + BIT;
      end else begin
        n_nxt   = n_p;
        res_nxt = res_p >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[s]   <= n_nxt;
        res_r[s] <= res_nxt;
      end
    end
  end

  assign root = res_r[SQRT_STAGES-1][WORD_W-1:0];

endmodule

// File: sv/v3a_div.sv
// ----------------------------------------------------------------------------
// v3a_div
// Pipelined restoring divider for one normalize lane: (a << FRAC_BITS) / mag,
// truncated toward zero. The quotient never exceeds 2^FRAC_BITS.
// ----------------------------------------------------------------------------
module v3a_div import v3a_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [WORD_W-1:0] a,
  input  logic [WORD_W-1:0]        mag,
  output logic signed [WORD_W-1:0] quo
);

  localparam int DS = FRAC_BITS + 1;

  logic [WORD_W-1:0] a_abs;
  logic [WORD_W-1:0] rem_r [DS];
  logic [DS-1:0]     q_r   [DS];
  logic [WORD_W-1:0] mag_r [DS];
  logic              neg_r [DS];

  assign a_abs = a[WORD_W-1] ? (~a + 1'b1) : a;

  for (genvar s = 0; s < DS; s++) begin : g_stage
    logic [WORD_W-1:0] rem_p, m_p;
    logic [DS-1:0]     q_p;
    logic              nbit, neg_p;
    logic [WORD_W:0]   part;
    logic [WORD_W-1:0] rem_nxt;
    logic [DS-1:0]     q_nxt;

    if (s == 0) begin : g_first
      // top bits of the numerator are already below the divisor
      assign rem_p = {1'b0, a_abs[WORD_W-1:1]};
      assign nbit  = a_abs[0];
      assign q_p   = '0;
      assign m_p   = mag;
      assign neg_p = a[WORD_W-1];
    end else begin : g_rest
      assign rem_p = rem_r[s-1];
      assign nbit  = 1'b0;
      assign q_p   = q_r[s-1];
      assign m_p   = mag_r[s-1];
      assign neg_p = neg_r[s-1];
    end

    always_comb begin
      part = {rem_p, nbit};
      if (part >= {1'b0, m_p}) begin
        rem_nxt = WORD_W'(part - {1'b0, m_p});
        q_nxt   = {q_p[DS-2:0], 1'b1};
      end else begin
        rem_nxt = part[WORD_W-1:0];
        q_nxt   = {q_p[DS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        q_r[s]   <= q_nxt;
        mag_r[s] <= m_p;
        neg_r[s] <= neg_p;
      end
    end
  end

  always_comb begin
    if (neg_r[DS-1]) begin
      quo = -WORD_W'(q_r[DS-1]);
    end else begin
      quo = WORD_W'(q_r[DS-1]);
    end
  end

endmodule

// File: sv/vector3_alu.sv
// ----------------------------------------------------------------------------
// vector3_alu
// Three-component Q16.16 vector unit: add, subtract, scale, hadamard,
// normalize, dot product and magnitude, with saturation and status.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one operation per transaction (operation, vectors A and B,
//   factor); out_ch returns one result per transaction (r_x, r_y, r_z,
//   scalar_out, status). Both channels use valid/ready.
//   The path has two lane stages, 32 square root stages, FRAC_BITS + 1
//   divider stages and the output register. Every operation takes the
//   full path so results stay in order. Throughput is one transaction per
//   cycle while out_ch is not stalled; each lane has its own multiplier
//   and divider, the square root pipeline is shared.
//   When out_ch is stalled with a result waiting the whole pipeline holds and
//   in_ch.ready drops until the result is taken.
//   Reset clears all valid flags; no result is pending afterwards.
// ----------------------------------------------------------------------------
`include "vector3_alu_macros.svh"

module vector3_alu import v3a_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  v3a_in_if.sink    in_ch,
  v3a_out_if.source out_ch
);

  localparam int DS  = FRAC_BITS + 1;
  localparam int LAT = 2 + SQRT_STAGES + DS + 1;

  typedef struct packed {
    op_t                      op;
    sat_t                     res_x;
    sat_t                     res_y;
    sat_t                     res_z;
    logic signed [WORD_W-1:0] a_x;
    logic signed [WORD_W-1:0] a_y;
    logic signed [WORD_W-1:0] a_z;
    sat_t                     dot;
    logic [WORD_W-1:0]        mag;
  } pay_t;

  logic                     en;
  op_t                      op_in;
  logic [LAT-1:0]           vld_r;

  logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;
  sat_t                     lres_x, lres_y, lres_z;
  logic signed [WORD_W-1:0] la_x, la_y, la_z;

  logic signed [SUM_W-1:0]  sum_nxt;
  op_t                      op1_r, op2_r;
  sat_t                     dot2_r;
  logic [SQ_W-1:0]          sq2_r;

  logic [WORD_W-1:0]        root;
  pay_t                     pay1_in, pay2_in, pfin;
  pay_t                     pay1_r [SQRT_STAGES];
  pay_t                     pay2_r [DS];
  logic signed [WORD_W-1:0] quo_x, quo_y, quo_z;

  logic signed [WORD_W-1:0] rx_nxt, ry_nxt, rz_nxt, sc_nxt;
  logic [1:0]               st_nxt;
  logic                     ovf;
  logic signed [WORD_W-1:0] rx_r, ry_r, rz_r, sc_r;
  logic [1:0]               st_r;

  assign en          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;
  assign op_in       = op_t'(in_ch.operation);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  v3a_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk(clk), .en(en), .op(op_in), .a(in_ch.a_x), .b(in_ch.b_x), .f(in_ch.factor),
    .prod_s1(prod_x), .res_s2(lres_x), .a_s2(la_x)
  );
  v3a_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk(clk), .en(en), .op(op_in), .a(in_ch.a_y), .b(in_ch.b_y), .f(in_ch.factor),
    .prod_s1(prod_y), .res_s2(lres_y), .a_s2(la_y)
  );
  v3a_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
    .clk(clk), .en(en), .op(op_in), .a(in_ch.a_z), .b(in_ch.b_z), .f(in_ch.factor),
    .prod_s1(prod_z), .res_s2(lres_z), .a_s2(la_z)
  );

  // merge: one adder gives both the dot sum and the sum of squares
  assign sum_nxt = SUM_W'(prod_x) + SUM_W'(prod_y) + SUM_W'(prod_z);

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r  <= op_in;
      op2_r  <= op1_r;
      dot2_r <= sat_word(sum_nxt >>> FRAC_BITS);
      sq2_r  <= sum_nxt[SQ_W-1:0];
    end
  end

  v3a_isqrt u_isqrt (.clk(clk), .en(en), .n_in(sq2_r), .root(root));

  always_comb begin
    pay1_in       = '0;
    pay1_in.op    = op2_r;
    pay1_in.res_x = lres_x;
    pay1_in.res_y = lres_y;
    pay1_in.res_z = lres_z;
    pay1_in.a_x   = la_x;
    pay1_in.a_y   = la_y;
    pay1_in.a_z   = la_z;
    pay1_in.dot   = dot2_r;
    pay2_in       = pay1_r[SQRT_STAGES-1];
    pay2_in.mag   = root;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay1_r[0] <= pay1_in;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        pay1_r[i] <= pay1_r[i-1];
      end
      pay2_r[0] <= pay2_in;
      for (int i = 1; i < DS; i++) begin
        pay2_r[i] <= pay2_r[i-1];
      end
    end
  end

  v3a_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk(clk), .en(en), .a(pay2_in.a_x), .mag(root), .quo(quo_x)
  );
  v3a_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk(clk), .en(en), .a(pay2_in.a_y), .mag(root), .quo(quo_y)
  );
  v3a_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
    .clk(clk), .en(en), .a(pay2_in.a_z), .mag(root), .quo(quo_z)
  );

  assign pfin = pay2_r[DS-1];

  always_comb begin
    rx_nxt = '0;
    ry_nxt = '0;
    rz_nxt = '0;
    sc_nxt = '0;
    ovf    = 1'b0;
    st_nxt = STAT_OK;
    case (pfin.op) inside
      OP_ADD, OP_SUB, OP_SCALE, OP_HADAMARD: begin
        rx_nxt = pfin.res_x.val;
        ry_nxt = pfin.res_y.val;
        rz_nxt = pfin.res_z.val;
        ovf    = pfin.res_x.ovf || pfin.res_y.ovf || pfin.res_z.ovf;
      end
      OP_NORM: begin
        if (pfin.mag == '0) begin
          st_nxt = STAT_ZERO_NORM;
        end else begin
          rx_nxt = quo_x;
          ry_nxt = quo_y;
          rz_nxt = quo_z;
        end
      end
      OP_DOT: begin
        sc_nxt = pfin.dot.val;
        ovf    = pfin.dot.ovf;
      end
      OP_MAG: begin
        if (pfin.mag[WORD_W-1]) begin
          sc_nxt = WORD_MAX;
          ovf    = 1'b1;
        end else begin
          sc_nxt = pfin.mag;
        end
      end
      default: begin
        ovf = 1'b0;
      end
    endcase
    if (st_nxt == STAT_OK && ovf) begin
      st_nxt = STAT_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r <= rx_nxt;
      ry_r <= ry_nxt;
      rz_r <= rz_nxt;
      sc_r <= sc_nxt;
      st_r <= st_nxt;
    end
  end

  assign out_ch.valid      = vld_r[LAT-1];
  assign out_ch.r_x        = rx_r;
  assign out_ch.r_y        = ry_r;
  assign out_ch.r_z        = rz_r;
  assign out_ch.scalar_out = sc_r;
  assign out_ch.status     = st_r;

  `V3A_ASSERT_IMP(a_zero_norm_clear, out_ch.valid && out_ch.status == STAT_ZERO_NORM, out_ch.r_x == '0 && out_ch.r_y == '0 && out_ch.r_z == '0 && out_ch.scalar_out == '0, "zero-length normalize with non-zero fields")
  `V3A_ASSERT_IMP(a_status_code, out_ch.valid, out_ch.status <= STAT_ZERO_NORM, "undefined status code")
  `V3A_ASSERT_NXT(a_stall_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.status) && $stable(out_ch.scalar_out), "stalled result changed")

endmodule
